/* design/mahf_pkg.sv */
// Shared types, constants and lookup functions of the audio header finder.
`timescale 1ns / 1ps
`default_nettype none

package mahf_pkg;

    // Buffer bound; the position counter saturates here
    localparam int MAX_BUFFER_BYTES = 65536;
    localparam int POS_W            = $clog2(MAX_BUFFER_BYTES + 1);

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] SYNC_MASK  = 8'hF8;
    localparam logic [7:0] LAYER_MASK = 8'h06;
    localparam logic [7:0] SRATE_MASK = 8'h0C;

    // Layer codes from the second header byte
    localparam logic [1:0] LAYER_RSVD = 2'd0;
    localparam logic [1:0] LAYER_III  = 2'd1;
    localparam logic [1:0] LAYER_II   = 2'd2;
    localparam logic [1:0] LAYER_I    = 2'd3;

    // Header bytes collected once the sync is complete
    localparam logic [1:0] HDR_BYTES = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [15:0] header_offset;
        logic [1:0]  layer_code;
        logic [18:0] rate_bps;
        logic [15:0] sample_rate;
        logic [1:0]  channel_mode;
    } t_out;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'b001,
        PH_COLLECT = 3'b010,
        PH_DONE    = 3'b100
    } t_phase;

    // Bit rate in kbit/s by layer and index
    function automatic logic [8:0] rate_kbps(input logic [1:0] layer, input logic [3:0] idx);
        logic [8:0] k;
        k = 9'd0;
        case (layer)
            LAYER_I: begin
                case (idx)
                    4'd1:    k = 9'd32;
                    4'd2:    k = 9'd64;
                    4'd3:    k = 9'd96;
                    4'd4:    k = 9'd128;
                    4'd5:    k = 9'd160;
                    4'd6:    k = 9'd192;
                    4'd7:    k = 9'd224;
                    4'd8:    k = 9'd256;
                    4'd9:    k = 9'd288;
                    4'd10:   k = 9'd320;
                    4'd11:   k = 9'd352;
                    4'd12:   k = 9'd384;
                    4'd13:   k = 9'd416;
                    4'd14:   k = 9'd448;
                    default: k = 9'd0;
                endcase
            end
            LAYER_II: begin
                case (idx)
                    4'd1:    k = 9'd32;
                    4'd2:    k = 9'd48;
                    4'd3:    k = 9'd56;
                    4'd4:    k = 9'd64;
                    4'd5:    k = 9'd80;
                    4'd6:    k = 9'd96;
                    4'd7:    k = 9'd112;
                    4'd8:    k = 9'd128;
                    4'd9:    k = 9'd160;
                    4'd10:   k = 9'd192;
                    4'd11:   k = 9'd224;
                    4'd12:   k = 9'd256;
                    4'd13:   k = 9'd320;
                    4'd14:   k = 9'd384;
                    default: k = 9'd0;
                endcase
            end
            LAYER_III: begin
                case (idx)
                    4'd1:    k = 9'd32;
                    4'd2:    k = 9'd40;
                    4'd3:    k = 9'd48;
                    4'd4:    k = 9'd56;
                    4'd5:    k = 9'd64;
                    4'd6:    k = 9'd80;
                    4'd7:    k = 9'd96;
                    4'd8:    k = 9'd112;
                    4'd9:    k = 9'd128;
                    4'd10:   k = 9'd160;
                    4'd11:   k = 9'd192;
                    4'd12:   k = 9'd224;
                    4'd13:   k = 9'd256;
                    4'd14:   k = 9'd320;
                    default: k = 9'd0;
                endcase
            end
            default: k = 9'd0;
        endcase
        return k;
    endfunction

    // Sample rate in Hz by frequency code
    function automatic logic [15:0] sample_hz(input logic [1:0] code);
        logic [15:0] s;
        case (code)
            2'd0:    s = 16'd44100;
            2'd1:    s = 16'd48000;
            2'd2:    s = 16'd32000;
            default: s = 16'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* design/mahf_hdr_decode.sv */
// Field decode of the three collected bytes of a four-byte audio frame header.
`timescale 1ns / 1ps
`default_nettype none

module mahf_hdr_decode (
    input  wire logic [23:0]              i_window,
    input  wire logic [mahf_pkg::POS_W-1:0] i_sync_offset,
    output mahf_pkg::t_out                o_hdr
);

    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [1:0]  layer;
    logic [7:0]  layer_bits;
    logic [7:0]  srate_bits;
    logic [18:0] kbps_ext;

    assign b1         = i_window[23:16];
    assign b2         = i_window[15:8];
    assign b3         = i_window[7:0];
    assign layer_bits = b1 & mahf_pkg::LAYER_MASK;
    assign srate_bits = b2 & mahf_pkg::SRATE_MASK;
    assign layer      = layer_bits[2:1];
    assign kbps_ext   = {10'd0, mahf_pkg::rate_kbps(layer, b2[7:4])};

    // Assemble the result; reserved layer falls out of the table as zero
    always_comb begin
        o_hdr               = '0;
        o_hdr.found         = 1'b1;
        o_hdr.header_offset = 16'(i_sync_offset);
        o_hdr.layer_code    = layer;
        o_hdr.rate_bps      = 19'(kbps_ext * 19'd1000);
        o_hdr.sample_rate   = mahf_pkg::sample_hz(srate_bits[3:2]);
        o_hdr.channel_mode  = b3[7:6];
    end

endmodule

`default_nettype wire

/* design/mpeg_audio_header_finder.sv */
// Top level: byte input register, sync search state and result register.
`timescale 1ns / 1ps
`default_nettype none

// Scans a buffer delivered one byte per transfer for the first MPEG-1 audio
// sync (0xFF then a byte with its top five bits set) and returns one result
// per buffer: the parsed header, or found = 0 with all fields zero when the
// buffer ends before the header is complete or the buffer bound is reached.
// Bytes after the result are dropped until the byte marked last, which
// restarts the search. One byte is taken every cycle while the output is not
// stalled; each byte passes through the input register, and the result it
// completes is formed combinationally with the state update and loaded into
// the result register. No clearing pass is needed after reset.
module mpeg_audio_header_finder (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire mahf_pkg::t_in  i_in,
    output logic                o_valid,
    input  wire logic           i_stall,
    output mahf_pkg::t_out      o_out
);

    localparam int POS_W = mahf_pkg::POS_W;

    // Input register
    logic           r_in_valid;
    mahf_pkg::t_in  r_in;

    // Search state
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [7:0]       r_prev,  n_prev;
    mahf_pkg::t_phase r_phase, n_phase;
    logic [23:0]      r_win,   n_win;
    logic [1:0]       r_cnt,   n_cnt;
    logic [POS_W-1:0] r_sync,  n_sync;

    // Result register
    logic           r_out_valid;
    mahf_pkg::t_out r_out;

    logic           out_free;
    logic           proc_go;
    logic           res_v;
    mahf_pkg::t_out res;
    mahf_pkg::t_out hdr;
    logic [23:0]    hdr_win;
    logic           at_bound;
    logic           sync_hit;
    logic [7:0]     d_masked;

    assign out_free = !r_out_valid || !i_stall;
    assign proc_go  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign o_valid  = r_out_valid;
    assign o_out    = r_out;

    assign at_bound = (r_pos == POS_W'(mahf_pkg::MAX_BUFFER_BYTES));
    assign d_masked = r_in.data_byte & mahf_pkg::SYNC_MASK;
    assign sync_hit = (r_pos != '0) && (r_prev == mahf_pkg::SYNC_BYTE)
                      && (d_masked == mahf_pkg::SYNC_MASK);

    // Header window with the current byte shifted in
    assign hdr_win  = {r_win[15:0], r_in.data_byte};

    mahf_hdr_decode u_decode (
        .i_window      (hdr_win),
        .i_sync_offset (r_sync),
        .o_hdr         (hdr)
    );

    // Next state and result for the byte in the input register
    always_comb begin
        n_pos   = r_pos;
        n_prev  = r_in.data_byte;
        n_phase = r_phase;
        n_win   = r_win;
        n_cnt   = r_cnt;
        n_sync  = r_sync;
        res_v   = 1'b0;
        res     = '0;

        case (r_phase)
            mahf_pkg::PH_SEARCH: begin
                if (at_bound) begin
                    res_v   = 1'b1;
                    n_phase = mahf_pkg::PH_DONE;
                end else if (sync_hit) begin
                    n_sync  = r_pos - POS_W'(1);
                    n_win   = {16'd0, r_in.data_byte};
                    n_cnt   = 2'd1;
                    n_phase = mahf_pkg::PH_COLLECT;
                end
            end
            mahf_pkg::PH_COLLECT: begin
                if (at_bound) begin
                    res_v   = 1'b1;
                    n_phase = mahf_pkg::PH_DONE;
                end else begin
                    n_win = hdr_win;
                    n_cnt = r_cnt + 2'd1;
                    if (n_cnt == mahf_pkg::HDR_BYTES) begin
                        res_v   = 1'b1;
                        res     = hdr;
                        n_phase = mahf_pkg::PH_DONE;
                    end
                end
            end
            mahf_pkg::PH_DONE: begin
                n_phase = mahf_pkg::PH_DONE;
            end
            default: begin
                n_phase = mahf_pkg::PH_SEARCH;
            end
        endcase

        // Advance the position, saturating at the bound
        if (!at_bound) begin
            n_pos = r_pos + POS_W'(1);
        end

        // Close the buffer: report not found if nothing was given yet
        if (r_in.last_byte) begin
            if (!res_v && (n_phase != mahf_pkg::PH_DONE)) begin
                res_v = 1'b1;
                res   = '0;
            end
            n_pos   = '0;
            n_prev  = 8'd0;
            n_phase = mahf_pkg::PH_SEARCH;
            n_win   = 24'd0;
            n_cnt   = 2'd0;
            n_sync  = '0;
        end
    end

    // Input register: take a byte when empty or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || proc_go) begin
            r_in_valid <= i_valid;
        end
        if ((!r_in_valid || proc_go) && i_valid) begin
            r_in <= i_in;
        end
    end

    // Search state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_prev  <= 8'd0;
            r_phase <= mahf_pkg::PH_SEARCH;
            r_win   <= 24'd0;
            r_cnt   <= 2'd0;
            r_sync  <= '0;
        end else if (proc_go) begin
            r_pos   <= n_pos;
            r_prev  <= n_prev;
            r_phase <= n_phase;
            r_win   <= n_win;
            r_cnt   <= n_cnt;
            r_sync  <= n_sync;
        end
    end

    // Result register: load a new result or drop the one transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && res_v) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (proc_go && res_v) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire
